FILE: design/mbsp_pkg.sv
// Shared types and constants for the MIDI byte stream parser.
// No dependencies; used by the channel interfaces and the parser.
package mbsp_pkg;

    // result kinds
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_NONE    = 3'd0;
    localparam kind_t KIND_MSG     = 3'd1;
    localparam kind_t KIND_SXLEN   = 3'd2;
    localparam kind_t KIND_SXDATA  = 3'd3;
    localparam kind_t KIND_SXEND   = 3'd4;

    // transport commands
    typedef logic [1:0] transport_t;
    localparam transport_t TRANSPORT_STOP = 2'd2;

    // status bytes with special handling
    localparam logic [7:0] ST_CLOCK      = 8'hF8;
    localparam logic [7:0] ST_START      = 8'hFA;
    localparam logic [7:0] ST_STOP       = 8'hFC;
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_MTC        = 8'hF1;
    localparam logic [7:0] ST_SONG_POS   = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
    localparam logic [7:0] ST_TUNE       = 8'hF6;
    localparam logic [7:0] ST_EOX        = 8'hF7;
    localparam logic [7:0] ST_NONE       = 8'h00;

    // configuration register indexes
    localparam logic REG_MANUFACTURER = 1'b0;
    localparam logic REG_PRODUCT      = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

endpackage

FILE: design/mbsp_byte_if.sv
// Request channel carrying one raw MIDI byte, plus the result channel.
// Depends on mbsp_pkg for payload types.
interface mbsp_byte_if
    import mbsp_pkg::*;
(
    input logic clk
);
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mbsp_result_if
    import mbsp_pkg::*;
(
    input logic clk
);
    logic        valid;
    logic        ready;
    kind_t       kind;
    logic [7:0]  status;
    logic [6:0]  data1;
    logic [6:0]  data2;
    logic [6:0]  sysex_position;
    logic [31:0] clock_count;
    transport_t  transport;

    modport source (output valid, output kind, output status, output data1, output data2,
                    output sysex_position, output clock_count, output transport,
                    input ready);
    modport sink   (input valid, input kind, input status, input data1, input data2,
                    input sysex_position, input clock_count, input transport,
                    output ready);
endinterface

FILE: design/midi_byte_stream_parser.sv
// MIDI byte stream parser top level: decode, state and result register.
// Depends on mbsp_pkg and the channel interfaces in mbsp_byte_if.sv.
//
// Usage:
//   stream carries one raw MIDI byte per request (valid/ready).
//   result carries exactly one result per accepted byte; kind none means
//   the byte produced no message but the clock count and transport are
//   still reported.
//   The APB port writes manufacturer_id (addr 0) and product_id (addr 4),
//   which select the sysex messages that get captured; write only when idle.
// Timing: a result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while results are taken; the decode is a single pass of logic
//   between the stream handshake and the result register.
// Stall: stream.ready stays high while the result register is empty or is
//   being taken in the same cycle; a stalled result holds its value and
//   blocks the next byte.
// Reset: rst_n clears running status, the pending message, sysex capture,
//   the clock counter and both ID registers; transport resets to stop.
module midi_byte_stream_parser
    import mbsp_pkg::*;
#(
    parameter int CLOCK_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    mbsp_byte_if.sink             stream,
    mbsp_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        PH_OFF  = 3'd0,
        PH_MANU = 3'd1,
        PH_PROD = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    // configuration registers
    logic [6:0] manufacturer_id_reg;
    logic [6:0] product_id_reg;
    logic       cfg_write;
    logic       cfg_index;

    // parser state
    logic [7:0]             running_status_reg, running_status_next;
    logic                   await_second_reg, await_second_next;
    logic [7:0]             pending_status_reg, pending_status_next;
    logic [6:0]             pending_first_reg, pending_first_next;
    phase_t                 phase_reg, phase_next;
    logic [6:0]             sysex_count_reg, sysex_count_next;
    logic [6:0]             sysex_length_reg, sysex_length_next;
    logic [CLOCK_WIDTH-1:0] clock_counter_reg, clock_counter_next;
    transport_t             transport_reg, transport_next;

    // result register
    logic        out_valid_reg;
    kind_t       kind_reg, kind_next;
    logic [7:0]  status_reg, status_next;
    logic [6:0]  data1_reg, data1_next;
    logic [6:0]  data2_reg, data2_next;
    logic [6:0]  position_reg, position_next;

    logic       accept;
    logic [7:0] b;
    logic [7:0] rs;

    // apb access, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[2];

    always_comb
    begin
        if (cfg_index == REG_MANUFACTURER)
            prdata = {25'd0, manufacturer_id_reg};
        else
            prdata = {25'd0, product_id_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manufacturer_id_reg <= 7'd0;
            product_id_reg      <= 7'd0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_MANUFACTURER)
                manufacturer_id_reg <= pwdata[6:0];
            else
                product_id_reg <= pwdata[6:0];
        end
    end

    // handshake: take a byte when the result slot is free or draining
    assign stream.ready = !out_valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;
    assign b            = stream.data_byte;
    assign rs           = running_status_reg;

    // byte decode and next state
    always_comb
    begin
        running_status_next = running_status_reg;
        await_second_next   = await_second_reg;
        pending_status_next = pending_status_reg;
        pending_first_next  = pending_first_reg;
        phase_next          = phase_reg;
        sysex_count_next    = sysex_count_reg;
        sysex_length_next   = sysex_length_reg;
        clock_counter_next  = clock_counter_reg;
        transport_next      = transport_reg;
        kind_next           = KIND_NONE;
        status_next         = ST_NONE;
        data1_next          = 7'd0;
        data2_next          = 7'd0;
        position_next       = 7'd0;

        if (b >= ST_CLOCK)
        begin
            // real-time bytes leave everything else alone
            if (b == ST_CLOCK)
                clock_counter_next = clock_counter_reg + CLOCK_WIDTH'(1);
            else if (b >= ST_START && b <= ST_STOP)
                transport_next = 2'(b - ST_START);
            else
            begin
                kind_next   = KIND_MSG;
                status_next = b;
            end
        end
        else if (b[7])
        begin
            // any other status byte ends capture and a pending message
            phase_next        = PH_OFF;
            await_second_next = 1'b0;
            if (b == ST_SYSEX)
            begin
                phase_next          = PH_MANU;
                running_status_next = ST_NONE;
            end
            else if (b == ST_EOX)
            begin
                running_status_next = ST_NONE;
                if (phase_reg == PH_DATA)
                    kind_next = KIND_SXEND;
            end
            else
            begin
                running_status_next = b;
                if (b == ST_TUNE)
                begin
                    kind_next   = KIND_MSG;
                    status_next = b;
                end
            end
        end
        else if (await_second_reg)
        begin
            await_second_next = 1'b0;
            kind_next         = KIND_MSG;
            status_next       = pending_status_reg;
            data1_next        = pending_first_reg;
            data2_next        = b[6:0];
        end
        else if (rs != ST_NONE)
        begin
            if (rs[7:6] == 2'b10 || rs[7:4] == 4'hE)
            begin
                // two data bytes: hold the first
                pending_status_next = rs;
                pending_first_next  = b[6:0];
                await_second_next   = 1'b1;
            end
            else if (rs[7:5] == 3'b110)
            begin
                kind_next   = KIND_MSG;
                status_next = rs;
                data1_next  = b[6:0];
            end
            else if (rs == ST_SONG_POS)
            begin
                running_status_next = ST_NONE;
                pending_status_next = rs;
                pending_first_next  = b[6:0];
                await_second_next   = 1'b1;
            end
            else if (rs == ST_MTC || rs == ST_SONG_SEL)
            begin
                running_status_next = ST_NONE;
                kind_next           = KIND_MSG;
                status_next         = rs;
                data1_next          = b[6:0];
            end
            else
                running_status_next = ST_NONE;
        end
        else
        begin
            // sysex capture
            case (phase_reg)
                PH_MANU:
                    phase_next = (b[6:0] == manufacturer_id_reg) ? PH_PROD : PH_OFF;
                PH_PROD:
                    phase_next = (b[6:0] == product_id_reg) ? PH_LEN : PH_OFF;
                PH_LEN:
                begin
                    sysex_length_next = b[6:0];
                    sysex_count_next  = 7'd0;
                    phase_next        = PH_DATA;
                    kind_next         = KIND_SXLEN;
                    data1_next        = b[6:0];
                end
                PH_DATA:
                begin
                    if (sysex_count_reg < sysex_length_reg)
                    begin
                        kind_next        = KIND_SXDATA;
                        data1_next       = b[6:0];
                        position_next    = sysex_count_reg;
                        sysex_count_next = sysex_count_reg + 7'd1;
                    end
                end
                default:
                    phase_next = phase_reg;
            endcase
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_status_reg <= ST_NONE;
            await_second_reg   <= 1'b0;
            pending_status_reg <= ST_NONE;
            pending_first_reg  <= 7'd0;
            phase_reg          <= PH_OFF;
            sysex_count_reg    <= 7'd0;
            sysex_length_reg   <= 7'd0;
            clock_counter_reg  <= '0;
            transport_reg      <= TRANSPORT_STOP;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                running_status_reg <= running_status_next;
                await_second_reg   <= await_second_next;
                pending_status_reg <= pending_status_next;
                pending_first_reg  <= pending_first_next;
                phase_reg          <= phase_next;
                sysex_count_reg    <= sysex_count_next;
                sysex_length_reg   <= sysex_length_next;
                clock_counter_reg  <= clock_counter_next;
                transport_reg      <= transport_next;
                out_valid_reg      <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= kind_next;
            status_reg   <= status_next;
            data1_reg    <= data1_next;
            data2_reg    <= data2_next;
            position_reg <= position_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = kind_reg;
    assign result.status         = status_reg;
    assign result.data1          = data1_reg;
    assign result.data2          = data2_reg;
    assign result.sysex_position = position_reg;
    assign result.clock_count    = 32'(clock_counter_reg);
    assign result.transport      = transport_reg;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for midi_byte_stream_parser: directed and random MIDI byte streams with
// a per-byte predictor. Depends on mbsp_pkg, mbsp_byte_if.sv and the parser.
module tb_top;
    import mbsp_pkg::*;

    localparam int LIMIT = 200_000;

    // status byte boundaries, codes the package does not name, and an alias for ST_MTC
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_PROG     = 8'hC0;
    localparam logic [7:0] ST_BEND     = 8'hE0;
    localparam logic [7:0] ST_QFRAME   = 8'hF1;
    localparam logic [7:0] ST_UNDEF_A  = 8'hF4;
    localparam logic [7:0] ST_UNDEF_B  = 8'hF5;
    localparam logic [7:0] ST_RESET    = 8'hFF;

    typedef enum logic [2:0] {SX_OFF, SX_MANU, SX_PROD, SX_LEN, SX_DATA} sx_phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  status;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic [6:0]  position;
        logic [31:0] clocks;
        transport_t  transport;
    } parse_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  src_valid = 1'b0;
    logic [7:0]            src_byte = '0;
    logic                  sink_ready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mbsp_byte_if   byte_ch (.clk(clk));
    mbsp_result_if res_ch (.clk(clk));

    assign byte_ch.valid     = src_valid;
    assign byte_ch.data_byte = src_byte;
    assign res_ch.ready      = sink_ready;

    midi_byte_stream_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (byte_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // bytes waiting to be sent and results still owed by the parser
    logic [7:0]    tx_bytes[$];
    parse_result_t expected_results[$];

    // parser state as the bench sees it
    logic [6:0]  manu_id = '0;
    logic [6:0]  prod_id = '0;
    logic [7:0]  run_status = ST_NONE;
    logic        await_data2 = 1'b0;
    logic [7:0]  held_status = '0;
    logic [6:0]  held_data1 = '0;
    sx_phase_t   sx_phase = SX_OFF;
    logic [6:0]  sx_count = '0;
    logic [6:0]  sx_length = '0;
    logic [31:0] clock_ticks = '0;
    transport_t  transport_now = TRANSPORT_STOP;

    // flow control between the stimulus, the sender and the receiver
    bit idle_on = 1'b0;
    bit src_hold = 1'b0;
    int src_gap = 0;
    int sink_gap = 0;
    int taken = 0;
    int taken_seen = 0;
    int stall_asks = 0;
    int stall_served = 0;

    int mismatches = 0;
    int cycles = 0;
    int n_bytes = 0;
    int n_kind[5] = '{default: 0};

    function automatic parse_result_t decode_midi_byte(input logic [7:0] b);
        parse_result_t r;
        logic          started;
        r = '0;
        r.kind = KIND_NONE;
        if (b >= ST_CLOCK) begin
            // real-time bytes leave running status and capture alone
            if (b == ST_CLOCK)
                clock_ticks = clock_ticks + 1;
            else if (b >= ST_START && b <= ST_STOP)
                transport_now = transport_t'(b - ST_START);
            else begin
                r.kind = KIND_MSG;
                r.status = b;
            end
        end else if (b[7]) begin
            started = (sx_phase == SX_DATA);
            sx_phase = SX_OFF;
            await_data2 = 1'b0;
            if (b == ST_SYSEX) begin
                sx_phase = SX_MANU;
                run_status = ST_NONE;
            end else if (b == ST_EOX) begin
                run_status = ST_NONE;
                if (started)
                    r.kind = KIND_SXEND;
            end else begin
                run_status = b;
                if (b == ST_TUNE) begin
                    r.kind = KIND_MSG;
                    r.status = b;
                end
            end
        end else if (await_data2) begin
            await_data2 = 1'b0;
            r.kind = KIND_MSG;
            r.status = held_status;
            r.data1 = held_data1;
            r.data2 = b[6:0];
        end else if (run_status != ST_NONE) begin
            if (run_status < ST_PROG || (run_status >= ST_BEND && run_status < ST_SYSEX)) begin
                held_status = run_status;
                held_data1 = b[6:0];
                await_data2 = 1'b1;
            end else if (run_status < ST_BEND) begin
                r.kind = KIND_MSG;
                r.status = run_status;
                r.data1 = b[6:0];
            end else if (run_status == ST_SONG_POS) begin
                held_status = run_status;
                held_data1 = b[6:0];
                await_data2 = 1'b1;
                run_status = ST_NONE;
            end else if (run_status == ST_MTC || run_status == ST_SONG_SEL) begin
                r.kind = KIND_MSG;
                r.status = run_status;
                r.data1 = b[6:0];
                run_status = ST_NONE;
            end else
                run_status = ST_NONE;
        end else begin
            // sysex header filter, then length and data
            case (sx_phase)
                SX_MANU: sx_phase = (b[6:0] == manu_id) ? SX_PROD : SX_OFF;
                SX_PROD: sx_phase = (b[6:0] == prod_id) ? SX_LEN : SX_OFF;
                SX_LEN:
                begin
                    sx_length = b[6:0];
                    sx_count = '0;
                    sx_phase = SX_DATA;
                    r.kind = KIND_SXLEN;
                    r.data1 = b[6:0];
                end
                SX_DATA:
                begin
                    if (sx_count < sx_length) begin
                        r.kind = KIND_SXDATA;
                        r.data1 = b[6:0];
                        r.position = sx_count;
                        sx_count = sx_count + 7'd1;
                    end
                end
                default: ;
            endcase
        end
        r.clocks = clock_ticks;
        r.transport = transport_now;
        return r;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // byte sender: holds a request until taken, idles in bursts
    always @(negedge clk)
    begin
        if (!src_valid || taken != taken_seen) begin
            taken_seen = taken;
            if (src_gap > 0) begin
                src_gap--;
                src_valid <= 1'b0;
            end else if (!rst_n || src_hold || tx_bytes.size() == 0)
                src_valid <= 1'b0;
            else if (idle_on && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(0, 8);
                src_valid <= 1'b0;
            end else begin
                src_valid <= 1'b1;
                src_byte <= tx_bytes[0];
            end
        end
    end

    // result receiver: random stall bursts plus one long hold on request
    always @(negedge clk)
    begin
        if (stall_asks != stall_served) begin
            stall_served = stall_asks;
            sink_gap = 120;
        end
        if (sink_gap > 0) begin
            sink_gap--;
            sink_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 8);
            sink_ready <= 1'b0;
        end else
            sink_ready <= 1'b1;
    end

    // monitor: check results, then predict for each accepted byte
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n) begin
            if (res_ch.valid && sink_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with kind %0d arrived with nothing expected", res_ch.kind);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, res_ch.kind);
                    check_field("status", want.status, res_ch.status);
                    check_field("data1", want.data1, res_ch.data1);
                    check_field("data2", want.data2, res_ch.data2);
                    check_field("sysex_position", want.position, res_ch.sysex_position);
                    check_field("clock_count", want.clocks, res_ch.clock_count);
                    check_field("transport", want.transport, res_ch.transport);
                    if (want.kind <= KIND_SXEND)
                        n_kind[want.kind]++;
                end
            end
            if (src_valid && byte_ch.ready) begin
                expected_results.push_back(decode_midi_byte(src_byte));
                void'(tx_bytes.pop_front());
                n_bytes++;
                taken++;
            end
        end
    end

    task automatic read_check(input logic idx, input logic [6:0] want);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field(idx == REG_MANUFACTURER ? "manufacturer_id" : "product_id",
                    {25'd0, want}, prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_id(input logic idx, input logic [6:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {25'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MANUFACTURER)
            manu_id = value;
        else
            prod_id = value;
        read_check(idx, value);
    endtask

    // occasionally slip a real-time byte in ahead of b
    task automatic push_byte(input logic [7:0] b);
        if ($urandom_range(0, 9) == 0)
            tx_bytes.push_back($urandom_range(0, 1) ? ST_CLOCK
                                                   : (ST_CLOCK | 8'($urandom_range(0, 7))));
        tx_bytes.push_back(b);
    endtask

    function automatic logic [7:0] rand_data();
        return {1'b0, 7'($urandom_range(0, 127))};
    endfunction

    // one well-formed message, or a broken one, or noise
    task automatic queue_sequence();
        logic [7:0] st;
        int         reps;
        int         len;
        int         cnt;
        int         sel;
        sel = $urandom_range(0, 19);
        if (sel <= 7) begin
            // channel voice with running status repeats, sometimes cut short
            st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
            push_byte(st);
            reps = $urandom_range(1, 4);
            for (int i = 0; i < reps; i++) begin
                cnt = (st >= ST_PROG && st < ST_BEND) ? 1 : 2;
                if ($urandom_range(0, 7) == 0)
                    cnt = 1;
                for (int j = 0; j < cnt; j++)
                    push_byte(rand_data());
            end
        end else if (sel <= 10) begin
            // system common, with stray data after the ones that take none
            case ($urandom_range(0, 5))
                0: st = ST_QFRAME;
                1: st = ST_SONG_POS;
                2: st = ST_SONG_SEL;
                3: st = ST_UNDEF_A;
                4: st = ST_UNDEF_B;
                default: st = ST_TUNE;
            endcase
            push_byte(st);
            if (st == ST_SONG_POS)
                cnt = 2;
            else if (st == ST_QFRAME || st == ST_SONG_SEL)
                cnt = 1;
            else
                cnt = $urandom_range(0, 1);
            for (int j = 0; j < cnt; j++)
                push_byte(rand_data());
        end else if (sel <= 15) begin
            // sysex mostly addressed to us
            push_byte(ST_SYSEX);
            push_byte($urandom_range(0, 7) == 0 ? rand_data() : {1'b0, manu_id});
            push_byte($urandom_range(0, 7) == 0 ? rand_data() : {1'b0, prod_id});
            sel = $urandom_range(0, 39);
            if (sel == 0)
                len = 127;
            else if (sel < 30)
                len = $urandom_range(0, 10);
            else
                len = $urandom_range(0, 127);
            push_byte(8'(len));
            cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len)
                                              : len + $urandom_range(0, 2);
            for (int j = 0; j < cnt; j++)
                push_byte(rand_data());
            if ($urandom_range(0, 7) == 0)
                push_byte(8'($urandom_range(ST_NOTE_OFF, ST_EOX)));
            else
                push_byte(ST_EOX);
        end else if (sel == 16) begin
            // sysex that never reaches its length byte
            push_byte(ST_SYSEX);
            cnt = $urandom_range(0, 2);
            for (int j = 0; j < cnt; j++)
                push_byte(rand_data());
            push_byte(ST_EOX);
        end else if (sel == 17) begin
            cnt = $urandom_range(1, 4);
            for (int j = 0; j < cnt; j++)
                push_byte(8'($urandom_range(0, 255)));
        end else if (sel == 18)
            push_byte(rand_data());
        else begin
            cnt = $urandom_range(1, 5);
            for (int j = 0; j < cnt; j++)
                tx_bytes.push_back(ST_CLOCK | 8'($urandom_range(0, 7)));
        end
    endtask

    task automatic queue_random(input int count);
        int target;
        target = tx_bytes.size() + count;
        while (tx_bytes.size() < target)
            queue_sequence();
    endtask

    task automatic wait_idle();
        while (tx_bytes.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int half;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        read_check(REG_MANUFACTURER, 7'd0);
        read_check(REG_PRODUCT, 7'd0);

        // directed: extremes, running status, real-time inside messages, capture
        write_id(REG_MANUFACTURER, 7'd0);
        write_id(REG_PRODUCT, 7'd127);
        tx_bytes = '{8'h00, ST_NOTE_OFF, 8'h00, 8'h7F, 8'h7F, 8'h00, 8'hC5, 8'h7F,
                     ST_CLOCK, ST_START, ST_STOP, ST_RESET, ST_TUNE, 8'h12,
                     ST_SONG_POS, 8'h01, ST_CLOCK, 8'h02,
                     ST_SYSEX, 8'h00, 8'h7F, 8'h02, 8'h55, 8'hFE, 8'h2A, 8'h33, ST_EOX};
        wait_idle();

        // opposite id extremes, with a long receiver hold midway
        idle_on = 1'b1;
        write_id(REG_MANUFACTURER, 7'd127);
        write_id(REG_PRODUCT, 7'd0);
        queue_random(350);
        half = tx_bytes.size() / 2;
        while (tx_bytes.size() > half)
            @(posedge clk);
        stall_asks++;
        wait_idle();

        // random ids, sender pauses until the parser has drained
        write_id(REG_MANUFACTURER, 7'($urandom_range(0, 127)));
        write_id(REG_PRODUCT, 7'($urandom_range(0, 127)));
        queue_random(350);
        half = tx_bytes.size() / 2;
        while (tx_bytes.size() > half)
            @(posedge clk);
        src_hold = 1'b1;
        while (src_valid || expected_results.size() != 0)
            @(posedge clk);
        src_hold = 1'b0;
        wait_idle();

        write_id(REG_MANUFACTURER, 7'($urandom_range(0, 127)));
        write_id(REG_PRODUCT, 7'd127);
        queue_random(350);
        wait_idle();

        // closing stretch at full rate
        idle_on = 1'b0;
        write_id(REG_MANUFACTURER, 7'($urandom_range(0, 127)));
        write_id(REG_PRODUCT, 7'($urandom_range(0, 127)));
        queue_random(350);
        wait_idle();

        $display("covered %0d bytes over five id settings: %0d messages, %0d silent",
                 n_bytes, n_kind[KIND_MSG], n_kind[KIND_NONE]);
        $display("sysex captures %0d, data bytes %0d, ends %0d; %0d mismatches",
                 n_kind[KIND_SXLEN], n_kind[KIND_SXDATA], n_kind[KIND_SXEND], mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/mbsp_pkg.sv
design/mbsp_byte_if.sv
design/midi_byte_stream_parser.sv
test/tb_top.sv
